/* src/rbs_pkg.sv */
// Shared types and constants for the record boundary scanner.
// No dependencies; compiled first.
`default_nettype none

package rbs_pkg;

    localparam int unsigned PADDR_W     = 6;
    localparam int unsigned PDATA_W     = 64;
    localparam int unsigned REG_IDX_W   = 3;
    localparam int unsigned DELIM_BITS  = 64;
    localparam int unsigned OUT_LINE_W  = 32;

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    // register index = paddr[5:3]
    localparam logic [REG_IDX_W-1:0] REG_CSV_MODE    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_QUOTE_CHAR  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ESCAPE_CHAR = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_LEN   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DELIM_BYTES = 3'd4;

    typedef struct packed {
        logic                  csv_mode;
        logic [7:0]            quote_char;
        logic [7:0]            escape_char;
        logic [3:0]            delim_len;
        logic [DELIM_BITS-1:0] delim_bytes;
    } t_cfg;

endpackage

`default_nettype wire

/* src/rbs_if.sv */
// Valid/ready channel interfaces for scanner input bytes and results.
// No dependencies.
`default_nettype none

interface rbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       chunk_start;
    logic       first_only;

    modport source (output valid, data_byte, chunk_start, first_only, input ready);
    modport sink   (input valid, data_byte, chunk_start, first_only, output ready);
endinterface

interface rbs_out_if;
    logic        valid;
    logic        ready;
    logic        record_end;
    logic [31:0] line_count;
    logic        quoted;

    modport source (output valid, record_end, line_count, quoted, input ready);
    modport sink   (input valid, record_end, line_count, quoted, output ready);
endinterface

`default_nettype wire

/* src/record_boundary_scanner.sv */
// Record boundary scanner top level: byte scan logic and result register.
// Depends on rbs_pkg, rbs_if (rbs_in_if / rbs_out_if) and rbs_regs.
//
// Usage:
//   i_byte_ch carries one data byte per transfer with chunk_start and
//   first_only. o_res_ch returns exactly one result per input byte:
//   record_end, the committed line count (saturated to 32 bits) and the
//   quote state after that byte.
//   The APB port (registers at byte address 8*index, 64-bit data) sets CSV
//   vs. text mode, quote/escape bytes and the 1..8 byte text delimiter.
//   Write it only while no results are outstanding. pready is tied high.
// Timing:
//   A byte's result is registered: a byte accepted at an edge has its result on
//   o_res_ch right after that edge. Throughput is one byte per cycle while
//   o_res_ch is ready; the scan state (quote, escape, delimiter window, line
//   counters) is a single register set updated by one combinational pass per byte.
// Stall:
//   The result register frees up in the same cycle its transfer completes,
//   so i_byte_ch.ready = result register empty or being taken. A stalled
//   receiver holds the result and stops input after one byte.
// Reset:
//   Synchronous, active low. Clears scan state, sets both line counters
//   to 1, empties the result register and loads register defaults.
`default_nettype none

module record_boundary_scanner
    import rbs_pkg::*;
#(
    parameter int unsigned MAX_DELIM_BYTES = 8,   // 1..8
    parameter int unsigned LINE_COUNT_BITS = 32   // 16..64
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    rbs_in_if.sink                  i_byte_ch,
    rbs_out_if.source               o_res_ch,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [PDATA_W-1:0] i_pwdata,
    output logic      [PDATA_W-1:0] o_prdata,
    output logic                    o_pready
);

    // Window keeps the bytes before the current one that a match can need.
    localparam int unsigned WIN_BYTES = (MAX_DELIM_BYTES > 1) ? MAX_DELIM_BYTES - 1 : 1;
    localparam int unsigned FILL_W    = $clog2(WIN_BYTES + 1);
    localparam int unsigned IDX_W     = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;

    t_cfg w_cfg;

    rbs_regs u_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_psel    (i_psel),
        .i_penable (i_penable),
        .i_pwrite  (i_pwrite),
        .i_paddr   (i_paddr),
        .i_pwdata  (i_pwdata),
        .o_prdata  (o_prdata),
        .o_cfg     (w_cfg)
    );

    assign o_pready = 1'b1;

    // ---------------- scan state ----------------
    logic                            r_quoted,    n_quoted;
    logic                            r_escape,    n_escape;
    logic                            r_end_seen,  n_end_seen;
    logic [LINE_COUNT_BITS-1:0]      r_running,   n_running;
    logic [LINE_COUNT_BITS-1:0]      r_committed, n_committed;
    logic [WIN_BYTES-1:0][7:0]       r_window,    n_window;
    logic [FILL_W-1:0]               r_fill,      n_fill;

    // ---------------- result register ----------------
    logic        r_out_valid;
    logic        r_record_end;
    logic [31:0] r_line_count;
    logic        r_quoted_out;

    logic w_accept;
    logic w_rec;
    logic w_match;
    logic [31:0] w_line_out;

    assign i_byte_ch.ready = !r_out_valid || o_res_ch.ready;
    assign w_accept        = i_byte_ch.valid && i_byte_ch.ready;

    // Chunk start clears quote/escape/window/end and drops uncommitted newlines.
    logic                       b_quoted, b_escape, b_end_seen;
    logic [LINE_COUNT_BITS-1:0] b_running;
    logic [WIN_BYTES-1:0][7:0]  b_window;
    logic [FILL_W-1:0]          b_fill;

    always_comb begin
        if (i_byte_ch.chunk_start) begin
            b_quoted   = 1'b0;
            b_escape   = 1'b0;
            b_end_seen = 1'b0;
            b_running  = r_committed;
            b_window   = '0;
            b_fill     = '0;
        end else begin
            b_quoted   = r_quoted;
            b_escape   = r_escape;
            b_end_seen = r_end_seen;
            b_running  = r_running;
            b_window   = r_window;
            b_fill     = r_fill;
        end
    end

    // Text-mode delimiter compare: newest byte pairs with the last delimiter byte.
    logic [MAX_DELIM_BYTES-1:0][7:0] w_recent;
    logic [3:0]                      w_len;

    always_comb begin
        w_recent[0] = i_byte_ch.data_byte;
        for (int j = 1; j < MAX_DELIM_BYTES; j++) begin
            w_recent[j] = b_window[j-1];
        end
    end

    always_comb begin
        if (w_cfg.delim_len == 4'd0) begin
            w_len = 4'd1;
        end else if (w_cfg.delim_len > 4'(MAX_DELIM_BYTES)) begin
            w_len = 4'(MAX_DELIM_BYTES);
        end else begin
            w_len = w_cfg.delim_len;
        end
    end

    always_comb begin
        logic [3:0] idx;
        idx     = '0;
        w_match = (4'(b_fill) + 4'd1) >= w_len;
        for (int k = 0; k < MAX_DELIM_BYTES; k++) begin
            idx = w_len - 4'(k) - 4'd1;
            if (4'(k) < w_len &&
                w_recent[idx[IDX_W-1:0]] != w_cfg.delim_bytes[8*k +: 8]) begin
                w_match = 1'b0;
            end
        end
    end

    // Next state for one accepted byte.
    always_comb begin
        n_quoted    = b_quoted;
        n_escape    = b_escape;
        n_end_seen  = b_end_seen;
        n_running   = b_running;
        n_committed = r_committed;
        n_window    = b_window;
        n_fill      = b_fill;
        w_rec       = 1'b0;
        // after the first end of a first-only chunk the byte is ignored
        if (!(b_end_seen && i_byte_ch.first_only)) begin
            if (w_cfg.csv_mode) begin
                // every newline counts, quoted or not, saturating
                if (i_byte_ch.data_byte == NEWLINE_BYTE && !(&b_running)) begin
                    n_running = b_running + LINE_COUNT_BITS'(1);
                end
                if (b_quoted) begin
                    if (!b_escape) begin
                        // closing quote wins when quote and escape bytes match
                        if (i_byte_ch.data_byte == w_cfg.quote_char) begin
                            n_quoted = 1'b0;
                        end else if (i_byte_ch.data_byte == w_cfg.escape_char) begin
                            n_escape = 1'b1;
                        end
                    end else begin
                        n_escape = 1'b0;
                    end
                end else if (i_byte_ch.data_byte == NEWLINE_BYTE) begin
                    w_rec       = 1'b1;
                    n_committed = n_running;
                end else if (i_byte_ch.data_byte == w_cfg.quote_char) begin
                    n_quoted = 1'b1;
                end
            end else begin
                w_rec = w_match;
            end
            n_window[0] = i_byte_ch.data_byte;
            for (int j = 1; j < WIN_BYTES; j++) begin
                n_window[j] = b_window[j-1];
            end
            if (b_fill != FILL_W'(WIN_BYTES)) begin
                n_fill = b_fill + FILL_W'(1);
            end
            if (w_rec) begin
                n_end_seen = 1'b1;
            end
        end
    end

    // Line count seen on the output saturates at 32 bits.
    generate
        if (LINE_COUNT_BITS > 32) begin : g_sat
            assign w_line_out = (|n_committed[LINE_COUNT_BITS-1:32]) ? '1
                                                                      : n_committed[31:0];
        end else begin : g_nosat
            assign w_line_out = 32'(n_committed);
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quoted    <= 1'b0;
            r_escape    <= 1'b0;
            r_end_seen  <= 1'b0;
            r_running   <= LINE_COUNT_BITS'(1);
            r_committed <= LINE_COUNT_BITS'(1);
            r_window    <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_quoted    <= n_quoted;
                r_escape    <= n_escape;
                r_end_seen  <= n_end_seen;
                r_running   <= n_running;
                r_committed <= n_committed;
                r_window    <= n_window;
                r_fill      <= n_fill;
                r_out_valid <= 1'b1;
            end else if (o_res_ch.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_record_end <= w_rec;
            r_line_count <= w_line_out;
            r_quoted_out <= n_quoted;
        end
    end

    assign o_res_ch.valid      = r_out_valid;
    assign o_res_ch.record_end = r_record_end;
    assign o_res_ch.line_count = r_line_count;
    assign o_res_ch.quoted     = r_quoted_out;

    // ---------------- assertions ----------------
    a_escape_in_quote: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_escape |-> r_quoted)
        else $error("escape pending outside a quoted region");

    a_commit_le_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_committed <= r_running)
        else $error("committed line count ahead of running count");

    a_first_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && r_end_seen && i_byte_ch.first_only && !i_byte_ch.chunk_start)
        |=> !o_res_ch.record_end)
        else $error("record end reported after first end of a first-only chunk");

    a_text_quote_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && !w_cfg.csv_mode && !i_byte_ch.chunk_start) |=> $stable(r_quoted))
        else $error("quote state changed in text mode");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(WIN_BYTES))
        else $error("window fill beyond window size");

endmodule

`default_nettype wire

/* src/rbs_regs.sv */
// APB-style configuration registers for the record boundary scanner.
// Depends on rbs_pkg.
`default_nettype none

module rbs_regs
    import rbs_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_psel,
    input  wire logic               i_penable,
    input  wire logic               i_pwrite,
    input  wire logic [PADDR_W-1:0] i_paddr,
    input  wire logic [PDATA_W-1:0] i_pwdata,
    output logic      [PDATA_W-1:0] o_prdata,
    output t_cfg                    o_cfg
);

    t_cfg                 r_cfg;
    logic                 w_wr;
    logic [REG_IDX_W-1:0] w_idx;

    assign w_wr  = i_psel && i_penable && i_pwrite;
    assign w_idx = i_paddr[PADDR_W-1:PADDR_W-REG_IDX_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.csv_mode    <= 1'b1;
            r_cfg.quote_char  <= 8'd34;
            r_cfg.escape_char <= 8'd34;
            r_cfg.delim_len   <= 4'd1;
            r_cfg.delim_bytes <= DELIM_BITS'(10);
        end else if (w_wr) begin
            case (w_idx)
                REG_CSV_MODE:    r_cfg.csv_mode    <= i_pwdata[0];
                REG_QUOTE_CHAR:  r_cfg.quote_char  <= i_pwdata[7:0];
                REG_ESCAPE_CHAR: r_cfg.escape_char <= i_pwdata[7:0];
                REG_DELIM_LEN:   r_cfg.delim_len   <= i_pwdata[3:0];
                REG_DELIM_BYTES: r_cfg.delim_bytes <= i_pwdata[DELIM_BITS-1:0];
                default: ;  // writes past the register list are dropped
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CSV_MODE:    o_prdata = PDATA_W'(r_cfg.csv_mode);
            REG_QUOTE_CHAR:  o_prdata = PDATA_W'(r_cfg.quote_char);
            REG_ESCAPE_CHAR: o_prdata = PDATA_W'(r_cfg.escape_char);
            REG_DELIM_LEN:   o_prdata = PDATA_W'(r_cfg.delim_len);
            REG_DELIM_BYTES: o_prdata = PDATA_W'(r_cfg.delim_bytes);
            default:         o_prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* tb/rbs_scan_checker.sv */
`timescale 1ns / 100ps
// Scoreboard for record_boundary_scanner: watches both channels and the APB bus,
// predicts one result per byte and compares it. Depends on rbs_pkg and rbs_if.

module rbs_scan_checker
    import rbs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    rbs_in_if                  in_ch,
    rbs_out_if                 out_ch,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,
    output int                 o_fail_count,
    output int                 o_pending,
    output int                 o_results,
    output int                 o_record_ends
);

    typedef struct packed {
        logic                  record_end;
        logic [OUT_LINE_W-1:0] line_count;
        logic                  quoted;
    } t_scan_result;

    t_scan_result due_results[$];

    // shadow registers and scan state
    t_cfg        cfg;
    logic        quote_open;
    logic        esc_armed;
    logic [31:0] lines_seen;
    logic [31:0] lines_committed;
    logic [55:0] window;
    logic [3:0]  window_fill;
    logic        end_seen;

    int fails;
    int results;
    int record_ends;

    function automatic logic delim_hit(input logic [63:0] recent);
        int n;
        n = int'(cfg.delim_len);
        if (n < 1) n = 1;
        if (n > 8) n = 8;
        if (int'(window_fill) + 1 < n) return 1'b0;
        for (int k = 0; k < n; k++) begin
            if (cfg.delim_bytes[8*k +: 8] != recent[8*(n-1-k) +: 8]) return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic cs, input logic fo,
                             output t_scan_result res);
        logic [63:0] recent;
        logic        hit;
        hit = 1'b0;
        if (cs) begin
            quote_open  = 1'b0;
            esc_armed   = 1'b0;
            window      = '0;
            window_fill = '0;
            end_seen    = 1'b0;
            lines_seen  = lines_committed;
        end
        // with first_only, bytes after the first end leave the state alone
        if (!(end_seen && fo)) begin
            recent = {window, b};
            if (cfg.csv_mode) begin
                if (b == NEWLINE_BYTE && lines_seen != '1) lines_seen = lines_seen + 1;
                if (quote_open) begin
                    if (!esc_armed) begin
                        if (b == cfg.quote_char) quote_open = 1'b0;
                        else if (b == cfg.escape_char) esc_armed = 1'b1;
                    end else begin
                        esc_armed = 1'b0;
                    end
                end else if (b == NEWLINE_BYTE) begin
                    hit             = 1'b1;
                    lines_committed = lines_seen;
                end else if (b == cfg.quote_char) begin
                    quote_open = 1'b1;
                end
            end else begin
                hit = delim_hit(recent);
            end
            window = recent[55:0];
            if (window_fill < 4'd7) window_fill = window_fill + 4'd1;
            if (hit) end_seen = 1'b1;
        end
        res = '{record_end: hit, line_count: lines_committed, quoted: quote_open};
    endtask

    always @(posedge i_clk) begin
        t_scan_result got;
        t_scan_result want;
        t_scan_result pred;
        if (!i_rst_n) begin
            cfg             = '{csv_mode: 1'b1, quote_char: 8'd34, escape_char: 8'd34,
                                delim_len: 4'd1, delim_bytes: 64'd10};
            quote_open      = 1'b0;
            esc_armed       = 1'b0;
            lines_seen      = 32'd1;
            lines_committed = 32'd1;
            window          = '0;
            window_fill     = '0;
            end_seen        = 1'b0;
            due_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[PADDR_W-1 -: REG_IDX_W])
                    REG_CSV_MODE:    cfg.csv_mode    = i_pwdata[0];
                    REG_QUOTE_CHAR:  cfg.quote_char  = i_pwdata[7:0];
                    REG_ESCAPE_CHAR: cfg.escape_char = i_pwdata[7:0];
                    REG_DELIM_LEN:   cfg.delim_len   = i_pwdata[3:0];
                    REG_DELIM_BYTES: cfg.delim_bytes = i_pwdata;
                    default: ;
                endcase
            end

            // result side first: a result never belongs to a byte taken at this edge
            if (out_ch.valid && out_ch.ready) begin
                got = '{record_end: out_ch.record_end, line_count: out_ch.line_count,
                        quoted: out_ch.quoted};
                if (due_results.size() == 0) begin
                    fails++;
                    if (fails <= 10)
                        $display("%0t: unexpected result: rec=%0b line=%0d q=%0b",
                                 $realtime, got.record_end, got.line_count, got.quoted);
                end else begin
                    want = due_results.pop_front();
                    results++;
                    if (want.record_end) record_ends++;
                    if (got.record_end !== want.record_end || got.line_count !== want.line_count
                        || got.quoted !== want.quoted) begin
                        fails++;
                        if (fails <= 10)
                            $display({"%0t: result %0d: rec exp %0b got %0b,",
                                      " line exp %0d got %0d, quoted exp %0b got %0b"},
                                     $realtime, results, want.record_end, got.record_end,
                                     want.line_count, got.line_count, want.quoted, got.quoted);
                    end
                end
            end

            if (in_ch.valid && in_ch.ready) begin
                scan_byte(in_ch.data_byte, in_ch.chunk_start, in_ch.first_only, pred);
                due_results.push_back(pred);
            end
        end
        o_fail_count  <= fails;
        o_pending     <= due_results.size();
        o_results     <= results;
        o_record_ends <= record_ends;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Top of the record_boundary_scanner bench: clock, reset, APB setup, byte stimulus
// and verdict. Depends on rbs_pkg, rbs_if, record_boundary_scanner, rbs_scan_checker.

module tb_top;
    import rbs_pkg::*;

    localparam int PHASE_ITEMS = 119;   // 12 register settings, ~1430 random bytes
    localparam int QUIET_LIMIT = 2000;  // cycles without any transfer before giving up

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int fail_count;
    int pending;
    int results;
    int record_ends;

    rbs_in_if  byte_ch ();
    rbs_out_if res_ch ();

    record_boundary_scanner uut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_ch (byte_ch),
        .o_res_ch  (res_ch),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    rbs_scan_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .in_ch         (byte_ch),
        .out_ch        (res_ch),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_results     (results),
        .o_record_ends (record_ends)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Current register image, kept here only to shape the stimulus.
    logic        cur_mode;
    logic [7:0]  cur_quote;
    logic [7:0]  cur_escape;
    logic [63:0] cur_delim;
    int          delim_n;       // effective delimiter length, 1..8
    logic        cur_fo;        // first_only level held across a chunk
    bit          idle_on = 1'b1;
    int          bytes_sent;
    int          settings;
    int          sent;

    // ------------------------------------------------------------------
    // Idling: mostly back-to-back or short gaps, now and then a long one.
    // ------------------------------------------------------------------
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int rx_stall();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // Receiver: bursts of ready broken by stalls; steady ready when idling is off.
    initial begin
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            res_ch.ready <= 1'b1;
            if (!idle_on) begin
                @(posedge i_clk);
            end else begin
                repeat ($urandom_range(1, 16)) @(posedge i_clk);
                res_ch.ready <= 1'b0;
                repeat (rx_stall()) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Byte transfer: optional gap, then hold valid until the edge that takes it.
    // valid stays high between back-to-back bytes (one update per step).
    // ------------------------------------------------------------------
    task automatic push_byte(input logic [7:0] b, input logic cs, input logic fo);
        int gap;
        gap = idle_gap();
        if (gap != 0) begin
            byte_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= b;
        byte_ch.chunk_start <= cs;
        byte_ch.first_only  <= fo;
        do @(posedge i_clk); while (!byte_ch.ready);
        bytes_sent++;
    endtask

    // Stop sending and wait for every outstanding result. The first edge lets
    // the checker's count catch up with a byte taken at the current edge.
    task automatic drain();
        byte_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // APB write: setup cycle, access cycle, done at the edge with pready high.
    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // All five registers are rewritten on every setting change, only when idle.
    task automatic set_config(input logic mode, input logic [7:0] q, input logic [7:0] e,
                              input logic [3:0] len, input logic [63:0] delim);
        drain();
        apb_write(REG_CSV_MODE, {63'd0, mode});
        apb_write(REG_QUOTE_CHAR, {56'd0, q});
        apb_write(REG_ESCAPE_CHAR, {56'd0, e});
        apb_write(REG_DELIM_LEN, {60'd0, len});
        apb_write(REG_DELIM_BYTES, delim);
        cur_mode   = mode;
        cur_quote  = q;
        cur_escape = e;
        cur_delim  = delim;
        delim_n    = (len == 4'd0) ? 1 : (len > 4'd8) ? 8 : int'(len);
        settings++;
    endtask

    // Chunk flags: a few percent of bytes open a chunk, first_only picked per chunk
    // and flipped mid-chunk once in a while.
    task automatic next_flags(output logic cs, output logic fo);
        cs = ($urandom_range(0, 99) < 4);
        if (cs) cur_fo = 1'($urandom_range(0, 1));
        else if ($urandom_range(0, 99) < 3) cur_fo = ~cur_fo;
        fo = cur_fo;
    endtask

    // CSV: heavy on newline, quote and escape so quoting nests and breaks often.
    task automatic csv_item();
        logic [7:0] b;
        logic       cs;
        logic       fo;
        int         r;
        r = $urandom_range(0, 99);
        if (r < 14)      b = NEWLINE_BYTE;
        else if (r < 26) b = cur_quote;
        else if (r < 34) b = cur_escape;
        else             b = 8'($urandom_range(0, 255));
        next_flags(cs, fo);
        push_byte(b, cs, fo);
        sent++;
    endtask

    // Text: whole delimiters (some as a chunk of their own), prefixes, single
    // delimiter bytes for overlaps, and plain noise.
    task automatic text_burst();
        logic cs;
        logic fo;
        int   r;
        int   k;
        int   n;
        r = $urandom_range(0, 99);
        if (r < 40) begin
            cs = ($urandom_range(0, 3) == 0);
            if (cs) cur_fo = 1'($urandom_range(0, 1));
            for (k = 0; k < delim_n; k++) begin
                push_byte(cur_delim[8*k +: 8], cs && k == 0, cur_fo);
                sent++;
            end
        end else if (r < 55 && delim_n > 1) begin
            n = $urandom_range(1, delim_n - 1);
            for (k = 0; k < n; k++) begin
                push_byte(cur_delim[8*k +: 8], 1'b0, cur_fo);
                sent++;
            end
        end else if (r < 75) begin
            k = $urandom_range(0, delim_n - 1);
            next_flags(cs, fo);
            push_byte(cur_delim[8*k +: 8], cs, fo);
            sent++;
        end else begin
            next_flags(cs, fo);
            push_byte(8'($urandom_range(0, 255)), cs, fo);
            sent++;
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n             <= 1'b0;
        psel                <= 1'b0;
        penable             <= 1'b0;
        pwrite              <= 1'b0;
        paddr               <= '0;
        pwdata              <= '0;
        byte_ch.valid       <= 1'b0;
        byte_ch.data_byte   <= '0;
        byte_ch.chunk_start <= 1'b0;
        byte_ch.first_only  <= 1'b0;
        cur_mode   = 1'b1;
        cur_quote  = 8'd34;
        cur_escape = 8'd34;
        cur_delim  = 64'd10;
        delim_n    = 1;
        cur_fo     = 1'b0;
        settings   = 1;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed, reset registers (CSV, quote == escape == '"').
        push_byte(8'h61, 1'b1, 1'b0);           // opens a chunk
        push_byte(8'h00, 1'b0, 1'b0);           // byte extremes
        push_byte(8'hFF, 1'b0, 1'b0);
        push_byte(NEWLINE_BYTE, 1'b0, 1'b0);    // bare newline ends a record
        push_byte(8'h22, 1'b0, 1'b0);           // open quote
        push_byte(NEWLINE_BYTE, 1'b0, 1'b0);    // quoted newline: counted, no end
        push_byte(8'h22, 1'b0, 1'b0);           // closes: quote wins over escape
        push_byte(8'h22, 1'b0, 1'b0);           // doubled quote reopens
        push_byte(8'h22, 1'b0, 1'b0);
        push_byte(NEWLINE_BYTE, 1'b0, 1'b0);    // commits both counted newlines
        push_byte(8'h22, 1'b0, 1'b0);
        push_byte(NEWLINE_BYTE, 1'b0, 1'b0);    // pending count in an open quote...
        push_byte(8'h41, 1'b1, 1'b0);           // ...dropped by a chunk start
        push_byte(NEWLINE_BYTE, 1'b0, 1'b0);
        push_byte(NEWLINE_BYTE, 1'b1, 1'b1);    // first-only chunk: first end marked
        push_byte(NEWLINE_BYTE, 1'b0, 1'b1);    // later bytes ignored
        push_byte(8'h22, 1'b0, 1'b1);
        push_byte(NEWLINE_BYTE, 1'b0, 1'b0);    // flag dropped: marks again
        push_byte(8'h55, 1'b0, 1'b0);
        push_byte(8'hAA, 1'b0, 1'b0);

        for (int p = 0; p < 12; p++) begin
            case (p)
                0:  set_config(1'b1, 8'h22, 8'h5C, 4'd1, 64'd10);
                1:  set_config(1'b1, 8'h27, 8'h27, 4'd8, '1);
                2:  set_config(1'b1, 8'h00, 8'hFF, 4'd1, 64'd0);
                3:  set_config(1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               4'($urandom_range(1, 8)), {$urandom, $urandom});
                4:  set_config(1'b0, 8'h22, 8'h22, 4'd1, 64'h0A);
                5:  set_config(1'b0, 8'h22, 8'h5C, 4'd2, 64'h0A0D);          // CR LF
                6:  set_config(1'b0, 8'hFF, 8'h00, 4'd8, {$urandom, $urandom});
                7:  set_config(1'b0, 8'h22, 8'h22, 4'd8, '1);
                8:  set_config(1'b0, 8'h22, 8'h22, 4'd3, 64'h616161);        // overlaps
                9:  set_config(1'b0, 8'h22, 8'h22, 4'd0, 64'd0);             // len 0 -> 1
                10: set_config(1'b0, 8'h22, 8'h22, 4'd15, {$urandom, $urandom}); // -> 8
                default: set_config(1'b1, NEWLINE_BYTE, 8'h22, 4'd4, 64'h0A0A0A0A);
            endcase
            // two settings run flat out on both sides
            idle_on = (p != 2 && p != 6);
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                if (p == 3 && sent == PHASE_ITEMS / 2) drain();  // hold off mid-phase
                if (cur_mode) csv_item();
                else text_burst();
            end
        end

        drain();
        repeat (4) @(posedge i_clk);
        $display("Sent %0d bytes across %0d register settings (CSV quoting, delimiters 1..8)",
                 bytes_sent, settings);
        $display("Checked %0d results, %0d of them record ends", results, record_ends);
        if (fail_count == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Watchdog: any transfer on either channel restarts the count.
    int quiet_cycles;
    always @(posedge i_clk) begin
        if (!i_rst_n || (byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
